// ===== design/max_min_spacing_search_core_macros.svh =====
// Assertion macros shared by the max/min spacing search core.
// No dependencies; included by the top level only.
`ifndef MAX_MIN_SPACING_SEARCH_CORE_MACROS_SVH
`define MAX_MIN_SPACING_SEARCH_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MMSS_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("mmss assertion failed");

// antecedent implies consequent in the next cycle
`define MMSS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("mmss assertion failed");

`endif

// ===== design/mmss_pkg.sv =====
// Package for the max/min spacing search core: sizes, read select codes,
// and the command/status structs between controller and datapath.
package mmss_pkg;

    localparam int MAX_POINTS = 64;
    localparam int POS_W      = 16;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int PICK_W     = 7;
    localparam logic [PICK_W-1:0] PICK_RESET = PICK_W'(2);

    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_IDX  = 2'd1,
        RD_LAST = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    sort_init;
        rd_sel_t rd_sel;
        logic    carry_load;
        logic    cmp_wr;
        logic    pass_end;
        logic    srch_init;
        logic    hi_load;
        logic    mid_load;
        logic    prev_load;
        logic    scan_cmp;
        logic    take_pass;
        logic    take_fail;
        logic    emit;
    } cmd_t;

    typedef struct packed {
        logic sort_done;
        logic pass_last;
        logic lo_gt_hi;
        logic need_le1;
        logic single;
        logic enough;
        logic mid_zero;
    } sts_t;

endpackage

// ===== design/mmss_ctrl.sv =====
// Controller for the max/min spacing search core: sequences load, bubble
// sort passes and the binary search over gaps. Depends on mmss_pkg.
module mmss_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic           last,
    input  logic           slot_free,
    input  mmss_pkg::sts_t sts,
    output logic           idle,
    output mmss_pkg::cmd_t cmd
);
    import mmss_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_PASS_INIT = 14'b00000000000010,
        S_CARRY     = 14'b00000000000100,
        S_RD        = 14'b00000000001000,
        S_CMP       = 14'b00000000010000,
        S_PASS_END  = 14'b00000000100000,
        S_SRCH_INIT = 14'b00000001000000,
        S_HI        = 14'b00000010000000,
        S_MID       = 14'b00000100000000,
        S_PREV      = 14'b00001000000000,
        S_SCAN_RD   = 14'b00010000000000,
        S_SCAN_CMP  = 14'b00100000000000,
        S_PASS      = 14'b01000000000000,
        S_FAIL      = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // done_reg marks the wait for a free output slot (search finished)
    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        cmd        = '0;
        cmd.rd_sel = RD_ZERO;
        idle       = 1'b0;
        if (done_reg)
        begin
            if (slot_free)
            begin
                cmd.emit   = 1'b1;
                done_next  = 1'b0;
                state_next = S_IDLE;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    idle          = 1'b1;
                    cmd.sort_init = 1'b1;
                    cmd.load      = in_fire;
                    if (in_fire && last)
                        state_next = S_PASS_INIT;
                end
                S_PASS_INIT:
                begin
                    if (sts.sort_done)
                        state_next = S_SRCH_INIT;
                    else
                        state_next = S_CARRY;
                end
                S_CARRY:
                begin
                    cmd.carry_load = 1'b1;
                    state_next     = S_RD;
                end
                S_RD:
                begin
                    cmd.rd_sel = RD_IDX;
                    state_next = S_CMP;
                end
                S_CMP:
                begin
                    cmd.cmp_wr = 1'b1;
                    state_next = sts.pass_last ? S_PASS_END : S_RD;
                end
                S_PASS_END:
                begin
                    cmd.pass_end = 1'b1;
                    state_next   = S_PASS_INIT;
                end
                S_SRCH_INIT:
                begin
                    cmd.srch_init = 1'b1;
                    cmd.rd_sel    = RD_LAST;
                    state_next    = S_HI;
                end
                S_HI:
                begin
                    cmd.hi_load = 1'b1;
                    state_next  = S_MID;
                end
                S_MID:
                begin
                    if (sts.lo_gt_hi)
                        done_next = 1'b1;
                    else
                    begin
                        cmd.mid_load = 1'b1;
                        state_next   = S_PREV;
                    end
                end
                S_PREV:
                begin
                    cmd.prev_load = 1'b1;
                    if (sts.need_le1)
                        state_next = S_PASS;
                    else if (sts.single)
                        state_next = S_FAIL;
                    else
                        state_next = S_SCAN_RD;
                end
                S_SCAN_RD:
                begin
                    cmd.rd_sel = RD_IDX;
                    state_next = S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    cmd.scan_cmp = 1'b1;
                    if (sts.enough)
                        state_next = S_PASS;
                    else if (sts.pass_last)
                        state_next = S_FAIL;
                    else
                        state_next = S_SCAN_RD;
                end
                S_PASS:
                begin
                    cmd.take_pass = 1'b1;
                    state_next    = S_MID;
                end
                S_FAIL:
                begin
                    if (sts.mid_zero)
                        done_next = 1'b1;
                    else
                    begin
                        cmd.take_fail = 1'b1;
                        state_next    = S_MID;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/mmss_dpath.sv =====
// Datapath for the max/min spacing search core: point memory, sort carry,
// search bounds and greedy scan registers. Depends on mmss_pkg.
module mmss_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mmss_pkg::cmd_t               cmd,
    input  logic [mmss_pkg::POS_W-1:0]   position,
    input  logic [mmss_pkg::PICK_W-1:0]  pick_count,
    output mmss_pkg::sts_t               sts,
    output logic [mmss_pkg::POS_W-1:0]   best_gap,
    output logic                         found,
    output logic                         overflow
);
    import mmss_pkg::*;

    logic [POS_W-1:0]  mem [MAX_POINTS];
    logic [POS_W-1:0]  rdata_reg;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [POS_W-1:0]  wdata;

    logic [CNT_W-1:0]  count_reg;
    logic              dropped_reg;
    logic [CNT_W-1:0]  pass_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  picked_reg;
    logic              found_reg;

    logic [POS_W-1:0]  carry_reg;
    logic [POS_W-1:0]  prev_reg;
    logic [POS_W:0]    lo_reg;
    logic [POS_W:0]    hi_reg;
    logic [POS_W-1:0]  mid_reg;
    logic [POS_W-1:0]  best_reg;

    logic [POS_W+1:0]  mid_sum;
    logic [POS_W-1:0]  diff;
    logic              hit;
    logic              carry_gt;
    logic              has_room;

    assign has_room = count_reg < CNT_W'(MAX_POINTS);
    assign carry_gt = carry_reg > rdata_reg;
    assign diff     = rdata_reg - prev_reg;
    assign hit      = diff >= mid_reg;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO: raddr = '0;
            RD_IDX:  raddr = idx_reg[ADDR_W-1:0];
            RD_LAST: raddr = ADDR_W'(count_reg - CNT_W'(1));
            default: raddr = '0;
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[ADDR_W-1:0];
        wdata = position;
        if (cmd.load && has_room)
            we = 1'b1;
        else if (cmd.cmp_wr)
        begin
            we    = 1'b1;
            waddr = ADDR_W'(idx_reg - CNT_W'(1));
            wdata = carry_gt ? rdata_reg : carry_reg;
        end
        else if (cmd.pass_end)
        begin
            we    = 1'b1;
            waddr = ADDR_W'(count_reg - CNT_W'(1));
            wdata = carry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            pass_reg    <= '0;
            idx_reg     <= '0;
            picked_reg  <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
            else if (cmd.load)
            begin
                if (has_room)
                    count_reg <= count_reg + CNT_W'(1);
                else
                    dropped_reg <= 1'b1;
            end
            if (cmd.sort_init)
                pass_reg <= '0;
            else if (cmd.pass_end)
                pass_reg <= pass_reg + CNT_W'(1);
            if (cmd.carry_load || cmd.prev_load)
                idx_reg <= CNT_W'(1);
            else if (cmd.cmp_wr || cmd.scan_cmp)
                idx_reg <= idx_reg + CNT_W'(1);
            if (cmd.prev_load)
                picked_reg <= CNT_W'(1);
            else if (cmd.scan_cmp && hit)
                picked_reg <= picked_reg + CNT_W'(1);
            if (cmd.srch_init)
                found_reg <= 1'b0;
            else if (cmd.take_pass)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.carry_load || (cmd.cmp_wr && !carry_gt))
            carry_reg <= rdata_reg;
        if (cmd.prev_load || (cmd.scan_cmp && hit))
            prev_reg <= rdata_reg;
        if (cmd.srch_init)
        begin
            lo_reg   <= '0;
            best_reg <= '0;
        end
        else if (cmd.take_pass)
        begin
            lo_reg   <= {1'b0, mid_reg} + (POS_W+1)'(1);
            best_reg <= mid_reg;
        end
        if (cmd.hi_load)
            hi_reg <= {1'b0, rdata_reg};
        else if (cmd.take_fail)
            hi_reg <= {1'b0, mid_reg} - (POS_W+1)'(1);
        if (cmd.mid_load)
            mid_reg <= mid_sum[POS_W:1];
    end

    assign sts.sort_done = ({1'b0, pass_reg} + (CNT_W+1)'(1)) == {1'b0, count_reg};
    assign sts.pass_last = ({1'b0, idx_reg} + (CNT_W+1)'(1)) == {1'b0, count_reg};
    assign sts.lo_gt_hi  = lo_reg > hi_reg;
    assign sts.need_le1  = pick_count <= PICK_W'(1);
    assign sts.single    = count_reg == CNT_W'(1);
    assign sts.enough    = hit
                           && (({1'b0, picked_reg} + (CNT_W+1)'(1)) >= (CNT_W+1)'(pick_count));
    assign sts.mid_zero  = mid_reg == '0;

    assign best_gap = found_reg ? best_reg : '0;
    assign found    = found_reg;
    assign overflow = dropped_reg;

endmodule

// ===== design/max_min_spacing_search_core.sv =====
// Top level of the max/min spacing search core: handshakes, pick_count
// register and result register. Uses mmss_pkg, mmss_ctrl and mmss_dpath.
//
//  channel  signals                          direction
//  in       in_valid/in_stall position last  beat in, stall driven here
//  out      out_valid/out_stall best_gap...  beat out, stall from sink
//  cfg      cfg_valid/cfg_ready cfg_data     pick_count write
//
// Positions load one per cycle while the core is idle. After the last beat
// the input stalls for n-1 bubble passes and then at most 17 gap probes,
// all of them bound by the single point memory port.
// The result waits in an output register; the next set may load meanwhile.
// Async active-low reset; pick_count resets to 2.
`include "max_min_spacing_search_core_macros.svh"

module max_min_spacing_search_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mmss_pkg::POS_W-1:0]   position,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mmss_pkg::POS_W-1:0]   best_gap,
    output logic                         found,
    output logic                         overflow,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mmss_pkg::PICK_W-1:0]  cfg_data
);
    import mmss_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic              idle;
    logic              in_fire;
    logic              slot_free;
    logic [PICK_W-1:0] pick_reg;
    logic              out_valid_reg;
    logic [POS_W-1:0]  best_gap_reg;
    logic              found_reg;
    logic              overflow_reg;
    logic [POS_W-1:0]  dp_gap;
    logic              dp_found;
    logic              dp_overflow;

    assign in_stall  = !idle;
    assign in_fire   = in_valid && idle;
    assign slot_free = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    mmss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .last      (last),
        .slot_free (slot_free),
        .sts       (sts),
        .idle      (idle),
        .cmd       (cmd)
    );

    mmss_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .position   (position),
        .pick_count (pick_reg),
        .sts        (sts),
        .best_gap   (dp_gap),
        .found      (dp_found),
        .overflow   (dp_overflow)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_reg      <= PICK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                pick_reg <= cfg_data;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            best_gap_reg <= dp_gap;
            found_reg    <= dp_found;
            overflow_reg <= dp_overflow;
        end
    end

    assign out_valid = out_valid_reg;
    assign best_gap  = best_gap_reg;
    assign found     = found_reg;
    assign overflow  = overflow_reg;

    `MMSS_ASSERT_IMPLY(a_emit_slot_free, clk, rst_n, cmd.emit, (!out_valid_reg || !out_stall))
    `MMSS_ASSERT_IMPLY(a_no_gap_unfound, clk, rst_n, (out_valid && !found), (best_gap == '0))
    `MMSS_ASSERT_NEXT(a_stall_after_last, clk, rst_n, (in_valid && !in_stall && last), in_stall)

endmodule

// ===== sim/spacing_checker.sv =====
// Scoreboard for max_min_spacing_search_core. It tracks pick_count writes,
// rebuilds each point set from the input beats and predicts its search
// result, then checks every output beat against it. Depends on mmss_pkg.
module spacing_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [mmss_pkg::POS_W-1:0]  position,
    input  logic                        last,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [mmss_pkg::POS_W-1:0]  best_gap,
    input  logic                        found,
    input  logic                        overflow,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [mmss_pkg::PICK_W-1:0] cfg_data,
    output int                          pending,
    output int                          mismatches,
    output int                          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import mmss_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] gap;
        logic             found;
        logic             overflow;
    } spacing_result_t;

    logic [POS_W-1:0]  set_points [MAX_POINTS];
    logic [POS_W-1:0]  ranked [MAX_POINTS];
    int                set_len;
    logic              set_dropped;
    logic [PICK_W-1:0] pick_reg;
    spacing_result_t   gap_queue [$];
    spacing_result_t   want;

    task automatic report_mismatch(input string what);
        $display("%0t ns spacing_checker: %s", $realtime, what);
        mismatches++;
    endtask

    // greedy placement over the sorted points, first point always taken
    function automatic bit spacing_ok(input int n, input int gap, input int need);
        int picked;
        int prev;
        int i;
        if (need <= 1)
            return 1'b1;
        picked = 1;
        prev = int'(ranked[0]);
        for (i = 1; i < n; i++)
        begin
            if (int'(ranked[i]) - prev >= gap)
            begin
                picked++;
                if (picked >= need)
                    return 1'b1;
                prev = int'(ranked[i]);
            end
        end
        return 1'b0;
    endfunction

    function automatic spacing_result_t predict_spacing(input int n,
                                                        input logic [PICK_W-1:0] need,
                                                        input logic dropped);
        spacing_result_t r;
        logic [POS_W-1:0] v;
        int lo;
        int hi;
        int mid;
        int i;
        int j;
        r = '0;
        r.overflow = dropped;
        if (n == 0)
            return r;
        for (i = 0; i < n; i++)
            ranked[i] = set_points[i];
        for (i = 1; i < n; i++)
        begin
            v = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] > v)
            begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = v;
        end
        lo = 0;
        hi = int'(ranked[n-1]);
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (spacing_ok(n, mid, int'(need)))
            begin
                r.gap = POS_W'(mid);
                r.found = 1'b1;
                lo = mid + 1;
            end
            else
            begin
                if (mid == 0)
                    break;
                hi = mid - 1;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_reg = PICK_RESET;
            set_len = 0;
            set_dropped = 1'b0;
            gap_queue.delete();
            mismatches = 0;
            results_seen = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                pick_reg = cfg_data;

            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (gap_queue.size() == 0)
                    report_mismatch("result beat with no set pending");
                else
                begin
                    want = gap_queue.pop_front();
                    if (best_gap !== want.gap)
                        report_mismatch($sformatf("best_gap got %h want %h",
                                                  best_gap, want.gap));
                    if (found !== want.found)
                        report_mismatch($sformatf("found got %b want %b",
                                                  found, want.found));
                    if (overflow !== want.overflow)
                        report_mismatch($sformatf("overflow got %b want %b",
                                                  overflow, want.overflow));
                end
            end

            if (in_valid && !in_stall)
            begin
                if (set_len < MAX_POINTS)
                begin
                    set_points[set_len] = position;
                    set_len++;
                end
                else
                    set_dropped = 1'b1;
                if (last)
                begin
                    gap_queue.push_back(predict_spacing(set_len, pick_reg, set_dropped));
                    set_len = 0;
                    set_dropped = 1'b0;
                end
            end

            pending <= gap_queue.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Top of the max_min_spacing_search_core bench: clock, reset, point-set
// stimulus with random gaps and output stalls, pick_count writes, verdict.
// Depends on mmss_pkg, max_min_spacing_search_core and spacing_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mmss_pkg::*;

    localparam int ITEM_TARGET    = 1850;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int DRAIN_CYCLES   = 32;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [POS_W-1:0]  position;
    logic              last;
    logic              out_valid;
    logic              out_stall;
    logic [POS_W-1:0]  best_gap;
    logic              found;
    logic              overflow;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [PICK_W-1:0] cfg_data;

    int                pending;
    int                mismatches;
    int                results_seen;
    bit                calm_src;
    bit                calm_sink;
    int                sink_hold;
    int                items_sent;
    int                sets_sent;
    int                pick_writes;
    logic [PICK_W-1:0] pick_now;

    max_min_spacing_search_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .position  (position),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .best_gap  (best_gap),
        .found     (found),
        .overflow  (overflow),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    spacing_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .position     (position),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .best_gap     (best_gap),
        .found        (found),
        .overflow     (overflow),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .mismatches   (mismatches),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sink: random stall ahead of each result beat
    always @(posedge clk or negedge rst_n)
    begin
        int hold_draw;
        if (!rst_n)
        begin
            sink_hold <= 0;
            out_stall <= 1'b0;
        end
        else if (out_valid && !out_stall)
        begin
            hold_draw = calm_sink ? 0 : int'($urandom_range(0, 13));
            sink_hold <= hold_draw;
            out_stall <= (hold_draw != 0);
        end
        else if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            out_stall <= (sink_hold > 1);
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog expired with %0d results outstanding", pending);
        $display("[max_min_spacing_search_core] ERROR");
        $finish;
    end

    task automatic send_point(input logic [POS_W-1:0] pos, input logic is_last);
        int gap;
        gap = calm_src ? 0 : int'($urandom_range(0, 13));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        position <= pos;
        last <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (is_last)
            sets_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_pick(input logic [PICK_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        pick_now = value;
        pick_writes++;
    endtask

    initial
    begin
        int r;
        int size;
        int style;
        int s;
        int k;
        int phase_sets;
        logic [POS_W-1:0] base;
        logic [POS_W-1:0] pos;

        rst_n = 1'b0;
        in_valid = 1'b0;
        position = '0;
        last = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        calm_src = 1'b0;
        calm_sink = 1'b0;
        items_sent = 0;
        sets_sent = 0;
        pick_writes = 0;
        pick_now = PICK_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of the position range, two picks
        set_pick(2);
        send_point(16'hFFFF, 1'b0);
        send_point(16'h0000, 1'b1);
        // lone point cannot hold two picks
        send_point(16'h0000, 1'b1);
        // single pick always fits
        set_pick(1);
        send_point(16'h1234, 1'b1);
        send_point(16'h0000, 1'b0);
        send_point(16'h0000, 1'b1);
        // zero pick behaves as one
        set_pick(0);
        send_point(16'h0005, 1'b0);
        send_point(16'hFFFF, 1'b0);
        send_point(16'h0007, 1'b1);
        // duplicates fit only at gap 0, then an unsorted set
        set_pick(3);
        repeat (3) send_point(16'h000A, 1'b0);
        send_point(16'h000A, 1'b1);
        send_point(16'd200, 1'b0);
        send_point(16'd0, 1'b0);
        send_point(16'd100, 1'b1);
        // more picks than points
        set_pick(127);
        send_point(16'd1, 1'b0);
        send_point(16'd2, 1'b0);
        send_point(16'd3, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 9);
            case (r)
                0: set_pick(0);
                1: set_pick(1);
                2: set_pick(127);
                3: set_pick(64);
                4: set_pick(PICK_W'($urandom_range(65, 126)));
                5: set_pick(PICK_W'($urandom_range(9, 63)));
                default: set_pick(PICK_W'($urandom_range(2, 8)));
            endcase
            calm_src = ($urandom_range(0, 3) == 0);
            calm_sink = ($urandom_range(0, 3) == 0);
            phase_sets = $urandom_range(1, 4);
            for (s = 0; s < phase_sets; s++)
            begin
                r = $urandom_range(0, 99);
                if (r < 25 && pick_now >= 2 && pick_now <= MAX_POINTS)
                    size = int'(pick_now) + int'($urandom_range(0, 5)) - 1;
                else if (r < 75)
                    size = $urandom_range(1, 12);
                else if (r < 90)
                    size = $urandom_range(13, 40);
                else if (r < 95)
                    size = MAX_POINTS;
                else
                    size = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 8);
                style = $urandom_range(0, 4);
                base = POS_W'($urandom_range(0, 65535));
                for (k = 0; k < size; k++)
                begin
                    case (style)
                        0: pos = POS_W'($urandom_range(0, 65535));
                        1: pos = POS_W'($urandom_range(0, 255));
                        2: pos = base + POS_W'($urandom_range(0, 63));
                        3: pos = base;
                        default: pos = $urandom_range(0, 1) ? '1 : '0;
                    endcase
                    send_point(pos, k == size - 1);
                end
            end
        end

        drain();
        $display("covered %0d positions in %0d sets under %0d pick_count writes",
                 items_sent, sets_sent, pick_writes);
        $display("compared %0d result beats, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("[max_min_spacing_search_core] OK");
        else
            $display("[max_min_spacing_search_core] ERROR");
        $finish;
    end

endmodule
